>>> rtl/sbrm_pkg.sv
package sbrm_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int OFF_W = $clog2(BLOCK_SIZE);
  localparam int BLK_W = $clog2(BLOCK_COUNT);
  localparam int VAL_W = 32;
  localparam int MIN_W = 34;
  localparam int CMD_W = 2;
  localparam int ST_W = 2;

  localparam logic signed [MIN_W-1:0] SENTINEL = 34'sh1_0000_0000;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

endpackage

>>> rtl/sbrm_ram.sv
module sbrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sqrt_block_range_minimum_top.sv
// Channel  Direction  Handshake              Fields
// item     in         start high, busy low   command, element_value, left_index, right_index
// result   out        done, one cycle        minimum, status
//
// Clear, rejected commands and the unused command give their result one cycle after start.
// An append takes one cycle, or two when the block minimum has to be read, compared and
// rewritten. A query issues one memory read per cycle, an element or a whole block minimum,
// and takes that many reads plus three cycles: at most 2*(BLOCK_SIZE-1)+BLOCK_COUNT+1.
// Synchronous reset clears the element count and the control state; the memories keep
// their contents. The receiver cannot stall, so busy depends only on the work in progress.
module sqrt_block_range_minimum_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sbrm_pkg::CMD_W-1:0]          command,
  input  logic signed [sbrm_pkg::VAL_W-1:0]   element_value,
  input  logic [sbrm_pkg::IDX_W-1:0]          left_index,
  input  logic [sbrm_pkg::IDX_W-1:0]          right_index,
  output logic                                done,
  output logic signed [sbrm_pkg::MIN_W-1:0]   minimum,
  output logic [sbrm_pkg::ST_W-1:0]           status
);

  import sbrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_APPEND = 3'b010,
    S_QUERY  = 3'b100
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic [IDX_W-1:0]         hi;
  logic signed [MIN_W-1:0]  best;
  logic                     pend;
  logic                     pend_blk;
  logic signed [VAL_W-1:0]  app_value;
  logic [BLK_W-1:0]         app_blk;

  logic                     accept;
  logic                     full;
  logic [BLK_W-1:0]         count_blk;
  logic                     count_first;

  logic                     elem_we;
  logic [VAL_W-1:0]         elem_rdata;
  logic                     blk_we;
  logic [BLK_W-1:0]         blk_waddr;
  logic [VAL_W-1:0]         blk_wdata;
  logic [BLK_W-1:0]         blk_raddr;
  logic [VAL_W-1:0]         blk_rdata;

  logic                     issue;
  logic                     whole;
  logic [CNT_W:0]           block_end;
  logic signed [MIN_W-1:0]  rd_value;
  logic signed [MIN_W-1:0]  best_next;

  assign busy = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign full = (count >= CNT_W'(MAX_ELEMENTS));
  assign count_blk = count[IDX_W-1:OFF_W];
  assign count_first = (count[OFF_W-1:0] == '0);

  assign elem_we = accept && (command == CMD_APPEND) && !full;

  always_comb begin
    if (state == S_APPEND) begin
      blk_we = ($signed(blk_rdata) > app_value);
      blk_waddr = app_blk;
      blk_wdata = app_value;
    end else begin
      blk_we = elem_we && count_first;
      blk_waddr = count_blk;
      blk_wdata = element_value;
    end
    blk_raddr = (state == S_QUERY) ? idx[IDX_W-1:OFF_W] : count_blk;
  end

  assign block_end = {1'b0, idx} + (CNT_W+1)'(BLOCK_SIZE - 1);
  assign issue = (idx <= {1'b0, hi});
  assign whole = (idx[OFF_W-1:0] == '0) && (block_end <= (CNT_W+1)'(hi));

  assign rd_value = pend_blk ? MIN_W'($signed(blk_rdata)) : MIN_W'($signed(elem_rdata));
  assign best_next = (pend && (rd_value < best)) ? rd_value : best;

  sbrm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_elem_ram (
    .clk  (clk),
    .we   (elem_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(element_value),
    .raddr(idx[IDX_W-1:0]),
    .rdata(elem_rdata)
  );

  sbrm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(BLOCK_COUNT)
  ) u_blk_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(blk_waddr),
    .wdata(blk_wdata),
    .raddr(blk_raddr),
    .rdata(blk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
      pend <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            minimum <= SENTINEL;
            status <= ST_OK;
            case (command)
              CMD_CLEAR: begin
                count <= '0;
                done <= 1'b1;
              end
              CMD_APPEND: begin
                if (full) begin
                  status <= ST_FULL;
                  done <= 1'b1;
                end else begin
                  count <= count + CNT_W'(1);
                  app_value <= element_value;
                  app_blk <= count_blk;
                  if (count_first) begin
                    done <= 1'b1;
                  end else begin
                    state <= S_APPEND;
                  end
                end
              end
              CMD_QUERY: begin
                if (left_index > right_index) begin
                  status <= ST_EMPTY;
                  done <= 1'b1;
                end else if ({1'b0, right_index} >= count) begin
                  status <= ST_RANGE;
                  done <= 1'b1;
                end else begin
                  idx <= {1'b0, left_index};
                  hi <= right_index;
                  best <= SENTINEL;
                  pend <= 1'b0;
                  state <= S_QUERY;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_APPEND: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_QUERY: begin
          best <= best_next;
          if (issue) begin
            pend <= 1'b1;
            pend_blk <= whole;
            idx <= whole ? (idx + CNT_W'(BLOCK_SIZE)) : (idx + CNT_W'(1));
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              minimum <= best;
              status <= ST_OK;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/sqrt_block_range_minimum_top_test.sv
module sqrt_block_range_minimum_top_test;
  import sbrm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        lo_idx;
    logic [IDX_W-1:0]        hi_idx;
  } cmd_item_t;

  typedef struct packed {
    logic signed [MIN_W-1:0] minimum;
    logic [ST_W-1:0]         status;
  } rmq_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        command = CMD_CLEAR;
  logic signed [VAL_W-1:0] element_value = '0;
  logic [IDX_W-1:0]        left_index = '0;
  logic [IDX_W-1:0]        right_index = '0;
  logic                    done;
  logic signed [MIN_W-1:0] minimum;
  logic [ST_W-1:0]         status;

  cmd_item_t   cmd_queue[$];
  rmq_result_t pending_results[$];

  logic signed [VAL_W-1:0] stored_values [MAX_ELEMENTS];
  int stored_count = 0;
  int gen_count = 0;
  int accepted_count = 0;
  int total_items = 0;
  int error_count = 0;
  int idle_cycles = 0;
  logic item_taken = 1'b0;

  sqrt_block_range_minimum_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .element_value(element_value),
    .left_index   (left_index),
    .right_index  (right_index),
    .done         (done),
    .minimum      (minimum),
    .status       (status)
  );

  always #10 clk = ~clk;

  task automatic predict_result(input cmd_item_t it, output rmq_result_t res);
    longint best;
    int i;
    res.minimum = SENTINEL;
    res.status = ST_OK;
    case (it.command)
      CMD_CLEAR: begin
        stored_count = 0;
      end
      CMD_APPEND: begin
        if (stored_count >= MAX_ELEMENTS) begin
          res.status = ST_FULL;
        end else begin
          stored_values[stored_count] = it.value;
          stored_count++;
        end
      end
      CMD_QUERY: begin
        if (it.lo_idx > it.hi_idx) begin
          res.status = ST_EMPTY;
        end else if (int'(it.hi_idx) >= stored_count) begin
          res.status = ST_RANGE;
        end else begin
          best = stored_values[it.lo_idx];
          for (i = int'(it.lo_idx) + 1; i <= int'(it.hi_idx); i++) begin
            if (stored_values[i] < best) best = stored_values[i];
          end
          res.minimum = best[MIN_W-1:0];
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                           input int lo, input int hi);
    cmd_item_t it;
    it.command = cmd;
    it.value = val;
    it.lo_idx = lo[IDX_W-1:0];
    it.hi_idx = hi[IDX_W-1:0];
    cmd_queue = {cmd_queue, it};
    if (cmd == CMD_CLEAR) gen_count = 0;
    else if (cmd == CMD_APPEND && gen_count < MAX_ELEMENTS) gen_count++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(20)) - 32'd10);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_valid_query();
    int hi;
    int lo;
    if (gen_count == 0) begin
      push_item(CMD_QUERY, $urandom, 0, 0);
    end else begin
      hi = $urandom_range(gen_count - 1, 0);
      case ($urandom_range(3))
        0: lo = $urandom_range(hi / BLOCK_SIZE, 0) * BLOCK_SIZE;
        1: begin
          lo = $urandom_range(hi, 0);
          if (hi / BLOCK_SIZE > lo / BLOCK_SIZE + 1)
            hi = (hi / BLOCK_SIZE) * BLOCK_SIZE - 1;
        end
        default: lo = $urandom_range(hi, 0);
      endcase
      push_item(CMD_QUERY, $urandom, lo, hi);
    end
  endtask

  initial begin
    int n;
    int r;
    bit filled;
    filled = 0;

    push_item(CMD_QUERY, 0, 0, 0);
    push_item(CMD_UNUSED, $urandom, $urandom_range(1023), $urandom_range(1023));
    push_item(CMD_QUERY, 0, 5, 3);
    push_item(CMD_APPEND, 32'sh8000_0000, 0, 0);
    push_item(CMD_APPEND, 32'sh7fff_ffff, 0, 0);
    push_item(CMD_APPEND, 0, 0, 0);
    push_item(CMD_APPEND, -1, 0, 0);
    push_item(CMD_QUERY, 0, 0, 3);
    push_item(CMD_QUERY, 0, 1, 1);
    push_item(CMD_QUERY, 0, 0, 0);
    push_item(CMD_QUERY, 0, 3, 3);
    push_item(CMD_QUERY, 0, 1, 3);
    push_item(CMD_QUERY, 0, 0, 4);
    push_item(CMD_QUERY, 0, 1023, 0);
    push_item(CMD_QUERY, 0, 1023, 1023);
    push_item(CMD_UNUSED, 32'sh7fff_ffff, 1023, 1023);
    push_item(CMD_CLEAR, $urandom, 1023, 1023);
    push_item(CMD_QUERY, 0, 0, 0);
    push_item(CMD_APPEND, 5, 0, 0);
    push_item(CMD_QUERY, 0, 0, 0);
    push_item(CMD_CLEAR, 0, 0, 0);

    while (cmd_queue.size() < TOTAL_ITEMS) begin
      r = $urandom_range(99);
      if (!filled && cmd_queue.size() > 400) begin
        // Fill the store to the top, query across all of it, then overflow it.
        while (gen_count < MAX_ELEMENTS) push_item(CMD_APPEND, pick_value(), 0, 0);
        push_item(CMD_QUERY, 0, 0, MAX_ELEMENTS - 1);
        push_item(CMD_QUERY, 0, 0, MAX_ELEMENTS - 2);
        push_item(CMD_QUERY, 0, BLOCK_SIZE, MAX_ELEMENTS - 1);
        push_item(CMD_QUERY, 0, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1);
        repeat (10) push_valid_query();
        repeat (3) push_item(CMD_APPEND, pick_value(), 0, 0);
        filled = 1;
      end else if (r < 4) begin
        push_item(CMD_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023));
      end else if (r < 40) begin
        n = $urandom_range(24, 1);
        repeat (n) push_item(CMD_APPEND, pick_value(), $urandom_range(1023), 0);
      end else if (r < 85) begin
        n = $urandom_range(6, 1);
        repeat (n) push_valid_query();
      end else begin
        push_item(2'($urandom_range(3)), $urandom, $urandom_range(1023), $urandom_range(1023));
      end
    end
    total_items = cmd_queue.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || start || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[sqrt_block_range_minimum_top] OK");
    end else begin
      $display("[sqrt_block_range_minimum_top] ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin : driver
    cmd_item_t it;
    int idle_pct;
    if (accepted_count < total_items / 3) idle_pct = 32;
    else if (accepted_count < (2 * total_items) / 3) idle_pct = 83;
    else idle_pct = 0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = cmd_queue.pop_front();
        command <= it.command;
        element_value <= it.value;
        left_index <= it.lo_idx;
        right_index <= it.hi_idx;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    cmd_item_t it;
    rmq_result_t want;
    rmq_result_t got;
    if (rst) begin
      item_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) begin
        got.minimum = minimum;
        got.status = status;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: minimum %0d status %0d", got.minimum, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.minimum !== want.minimum || got.status !== want.status) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: expected minimum %0d status %0d, got minimum %0d status %0d",
                       want.minimum, want.status, got.minimum, got.status);
          end
        end
      end
      if (start && !busy) begin
        it.command = command;
        it.value = element_value;
        it.lo_idx = left_index;
        it.hi_idx = right_index;
        predict_result(it, want);
        pending_results = {pending_results, want};
        accepted_count++;
      end
      item_taken <= start && !busy;
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[sqrt_block_range_minimum_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
